### sv/dns_query_validator_unit_defines.svh
// assertion macros for the dns query validator unit
`ifndef DNS_QUERY_VALIDATOR_UNIT_DEFINES_SVH
`define DNS_QUERY_VALIDATOR_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define DNSQV_ASSERT_IMPL(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("dnsqv check failed");
`define DNSQV_ASSERT_NEXT(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("dnsqv check failed");
`else
`define DNSQV_ASSERT_IMPL(name, clk, rst_n, pre, post)
`define DNSQV_ASSERT_NEXT(name, clk, rst_n, pre, post)
`endif

`endif

### sv/dnsqv_pkg.sv
// shared types and constants of the dns query validator
`timescale 1ns / 1ps

package dnsqv_pkg;

  localparam int unsigned MaxMessage = 512;
  localparam int unsigned HdrLen     = 12;
  localparam int unsigned MaxLabel   = 63;
  localparam int unsigned QtailLen   = 4;
  localparam int unsigned ClassIn    = 1;
  localparam int unsigned QdCountOk  = 1;
  localparam int unsigned PosMax     = 1023;
  localparam int unsigned QlenMax    = 511;

  typedef enum logic [1:0] {
    StForward = 2'd0,
    StFormErr = 2'd1,
    StNotImpl = 2'd2,
    StDropped = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [9:0] msg_length;
    logic       last;
  } in_word_t;

  typedef struct packed {
    logic [15:0] query_id;
    status_e     status;
    logic [8:0]  question_length;
  } res_t;

endpackage

### sv/dnsqv_if.sv
// stream interfaces for message bytes and verdicts
`timescale 1ns / 1ps

interface dnsqv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [9:0] msg_length;
  logic       last;

  modport source (output valid, data_byte, msg_length, last, input ready);
  modport sink (input valid, data_byte, msg_length, last, output ready);
endinterface

interface dnsqv_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] query_id;
  logic [1:0]  status;
  logic [8:0]  question_length;

  modport source (output valid, query_id, status, question_length, input ready);
  modport sink (input valid, query_id, status, question_length, output ready);
endinterface

### sv/dnsqv_in_stage.sv
// input register for message bytes
`timescale 1ns / 1ps

module dnsqv_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  dnsqv_pkg::in_word_t word_i,
  input  logic               out_free_i,
  output logic               advance_o,
  output logic               valid_o,
  output dnsqv_pkg::in_word_t word_o
);
  import dnsqv_pkg::*;

  logic     valid_q, valid_d;
  in_word_t word_q;
  logic     accept;

  // a last byte needs room in the result register
  assign advance_o = valid_q && (!word_q.last || out_free_i);
  assign ready_o   = !valid_q || advance_o;
  assign accept    = valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      word_q <= word_i;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;
endmodule

### sv/dnsqv_parser.sv
// per-byte header and question parser with message state
`timescale 1ns / 1ps

module dnsqv_parser #(
  parameter int unsigned MaxMsgLen = dnsqv_pkg::MaxMessage
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  dnsqv_pkg::in_word_t word_i,
  output dnsqv_pkg::res_t    res_o
);
  import dnsqv_pkg::*;

  typedef enum logic [2:0] {
    PhHeader,
    PhLen,
    PhBody,
    PhTail,
    PhDone
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [9:0]  pos_q, pos_d;
  logic [5:0]  rem_q, rem_d;
  logic [15:0] id_q, id_d;
  logic [7:0]  flags_q, flags_d;
  logic [15:0] qdcount_q, qdcount_d;
  logic [7:0]  class_hi_q, class_hi_d;
  status_e     err_q, err_d;
  logic [9:0]  qend_q, qend_d;

  logic [7:0]  b;
  logic [9:0]  eff_len;
  logic [10:0] need;
  logic [9:0]  qdiff;
  status_e     status;

  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q;
    rem_d      = rem_q;
    id_d       = id_q;
    flags_d    = flags_q;
    qdcount_d  = qdcount_q;
    class_hi_d = class_hi_q;
    err_d      = err_q;
    qend_d     = qend_q;
    status     = StFormErr;
    qdiff      = 10'd0;
    res_o      = '0;

    b = word_i.data_byte;
    if (32'(word_i.msg_length) > MaxMsgLen) begin
      eff_len = 10'(MaxMsgLen);
    end else begin
      eff_len = word_i.msg_length;
    end
    need = 11'(pos_q) + 11'(b) + 11'(QtailLen + 1);

    if (step_i) begin
      if (pos_q < eff_len) begin
        case (phase_q)
          PhHeader: begin
            if (pos_q >= 10'(HdrLen)) begin
              err_d   = StFormErr;
              phase_d = PhDone;
            end else begin
              case (pos_q)
                10'd0: id_d[15:8] = b;
                10'd1: id_d[7:0] = b;
                10'd2: flags_d = b;
                10'd4: qdcount_d[15:8] = b;
                10'd5: qdcount_d[7:0] = b;
                default: ;
              endcase
              if (pos_q == 10'(HdrLen - 1)) begin
                // response and truncation bits, single question
                if (flags_q[7] || flags_q[1] || qdcount_q != 16'(QdCountOk)) begin
                  err_d   = StFormErr;
                  phase_d = PhDone;
                end else begin
                  phase_d = PhLen;
                end
              end
            end
          end
          PhLen: begin
            if (b > 8'(MaxLabel) || need > {1'b0, eff_len}) begin
              err_d   = StFormErr;
              phase_d = PhDone;
            end else if (b == 8'd0) begin
              rem_d   = 6'(QtailLen);
              phase_d = PhTail;
            end else begin
              rem_d   = b[5:0];
              phase_d = PhBody;
            end
          end
          PhBody: begin
            rem_d = rem_q - 6'd1;
            if (rem_q == 6'd1) begin
              phase_d = PhLen;
            end
          end
          PhTail: begin
            if (rem_q == 6'd2) begin
              class_hi_d = b;
            end else if (rem_q == 6'd1) begin
              qend_d  = pos_q + 10'd1;
              err_d   = ({class_hi_q, b} != 16'(ClassIn)) ? StNotImpl : StForward;
              phase_d = PhDone;
            end
            rem_d = rem_q - 6'd1;
          end
          default: ;
        endcase
      end

      if (pos_q != 10'(PosMax)) begin
        pos_d = pos_q + 10'd1;
      end

      // verdict from the state this byte leaves
      if (eff_len <= 10'(HdrLen)) begin
        status = StDropped;
      end else if (phase_d != PhDone) begin
        status = StFormErr;
      end else begin
        status = err_d;
      end

      res_o.query_id = id_d;
      res_o.status   = status;
      if (status == StForward && qend_d >= 10'(HdrLen)) begin
        qdiff = qend_d - 10'(HdrLen);
        if (qdiff > 10'(QlenMax)) begin
          res_o.question_length = 9'(QlenMax);
        end else begin
          res_o.question_length = qdiff[8:0];
        end
      end

      if (word_i.last) begin
        phase_d    = PhHeader;
        pos_d      = 10'd0;
        rem_d      = 6'd0;
        id_d       = 16'd0;
        flags_d    = 8'd0;
        qdcount_d  = 16'd0;
        class_hi_d = 8'd0;
        err_d      = StForward;
        qend_d     = 10'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhHeader;
      pos_q      <= 10'd0;
      rem_q      <= 6'd0;
      id_q       <= 16'd0;
      flags_q    <= 8'd0;
      qdcount_q  <= 16'd0;
      class_hi_q <= 8'd0;
      err_q      <= StForward;
      qend_q     <= 10'd0;
    end else begin
      phase_q    <= phase_d;
      pos_q      <= pos_d;
      rem_q      <= rem_d;
      id_q       <= id_d;
      flags_q    <= flags_d;
      qdcount_q  <= qdcount_d;
      class_hi_q <= class_hi_d;
      err_q      <= err_d;
      qend_q     <= qend_d;
    end
  end
endmodule

### sv/dnsqv_out_stage.sv
// result register toward the verdict stream
`timescale 1ns / 1ps

module dnsqv_out_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  dnsqv_pkg::res_t res_i,
  input  logic            ready_i,
  output logic            out_free_o,
  output logic            valid_o,
  output dnsqv_pkg::res_t res_o
);
  import dnsqv_pkg::*;

  logic valid_q, valid_d;
  res_t res_q;

  assign out_free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;
endmodule

### sv/dns_query_validator_unit.sv
// Takes one DNS message byte per cycle and gives one verdict word per message,
// loaded into the result register as its last byte leaves the input register.
// Every byte passes an input register, one combinational parse step and, for
// the last byte, the result register, so a new byte can be taken every cycle.
// Input stalls only while a last byte waits on a result word not yet taken.
`timescale 1ns / 1ps
`include "dns_query_validator_unit_defines.svh"

module dns_query_validator_unit #(
  parameter int unsigned MaxMsgLen = dnsqv_pkg::MaxMessage
) (
  input logic              clk_i,
  input logic              rst_ni,
  dnsqv_in_if.sink         in_i,
  dnsqv_out_if.source      out_o
);
  import dnsqv_pkg::*;

  in_word_t in_word;
  in_word_t stg_word;
  logic     stg_valid;
  logic     in_ready;
  logic     advance;
  logic     out_free;
  res_t     step_res;
  res_t     res_word;
  logic     res_valid;

  assign in_word.data_byte  = in_i.data_byte;
  assign in_word.msg_length = in_i.msg_length;
  assign in_word.last       = in_i.last;
  assign in_i.ready         = in_ready;

  dnsqv_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (in_i.valid),
    .ready_o    (in_ready),
    .word_i     (in_word),
    .out_free_i (out_free),
    .advance_o  (advance),
    .valid_o    (stg_valid),
    .word_o     (stg_word)
  );

  dnsqv_parser #(
    .MaxMsgLen (MaxMsgLen)
  ) u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .word_i (stg_word),
    .res_o  (step_res)
  );

  dnsqv_out_stage u_out_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (advance && stg_word.last),
    .res_i      (step_res),
    .ready_i    (out_o.ready),
    .out_free_o (out_free),
    .valid_o    (res_valid),
    .res_o      (res_word)
  );

  assign out_o.valid           = res_valid;
  assign out_o.query_id        = res_word.query_id;
  assign out_o.status          = res_word.status;
  assign out_o.question_length = res_word.question_length;

  `DNSQV_ASSERT_NEXT(a_last_loads_result, clk_i, rst_ni, advance && stg_word.last, res_valid)
  `DNSQV_ASSERT_IMPL(a_last_waits_on_full, clk_i, rst_ni, stg_valid && stg_word.last && res_valid && !out_o.ready, !advance)
  `DNSQV_ASSERT_IMPL(a_qlen_only_forward, clk_i, rst_ni, res_valid && res_word.status != StForward, res_word.question_length == 9'd0)
endmodule

### tb/tb_top.sv
// testbench for the dns query validator: message byte stimulus with a verdict predictor
`timescale 1ns / 1ps

module tb_top;
  import dnsqv_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  typedef enum logic [2:0] {
    PhHeader,
    PhLabelLen,
    PhLabelBody,
    PhTypeClass,
    PhDone
  } parse_phase_e;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned HoldCycles = 120;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned RandomBytes = 60;
  localparam int unsigned RandomMsgs = 3;

  logic clk;
  logic rst_n;

  dnsqv_in_if  byte_if ();
  dnsqv_out_if verdict_if ();

  dns_query_validator_unit dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (byte_if),
    .out_o (verdict_if)
  );

  int unsigned in_idle_pct;
  int unsigned out_idle_pct;
  logic        hold_req;
  int unsigned errors;
  int unsigned bytes_sent;
  int unsigned msgs_sent;

  res_t verdict_q[$];

  // predicted parser state
  logic [9:0]   msg_pos;
  parse_phase_e phase;
  int unsigned  label_left;
  logic [15:0]  hdr_id;
  logic [7:0]   hdr_flags;
  logic [15:0]  hdr_qdcount;
  logic [15:0]  qclass_seen;
  status_e      parse_verdict;
  int unsigned  question_end;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic clear_parse();
    msg_pos       = '0;
    phase         = PhHeader;
    label_left    = 0;
    hdr_id        = '0;
    hdr_flags     = '0;
    hdr_qdcount   = '0;
    qclass_seen   = '0;
    parse_verdict = StForward;
    question_end  = 0;
  endtask

  task automatic predict_verdict(input in_word_t w);
    int unsigned eff_len;
    int unsigned p;
    int unsigned b;
    int unsigned qlen;
    status_e     st;
    res_t        v;
    eff_len = (w.msg_length > MaxMessage) ? MaxMessage : w.msg_length;
    p = msg_pos;
    b = w.data_byte;
    if (p < eff_len) begin
      case (phase)
        PhHeader: begin
          if (p >= HdrLen) begin
            parse_verdict = StFormErr;
            phase = PhDone;
          end else begin
            case (p)
              0: hdr_id[15:8] = w.data_byte;
              1: hdr_id[7:0] = w.data_byte;
              2: hdr_flags = w.data_byte;
              4: hdr_qdcount[15:8] = w.data_byte;
              5: hdr_qdcount[7:0] = w.data_byte;
              default: ;
            endcase
            if (p == HdrLen - 1) begin
              if (hdr_flags[7] || hdr_flags[1] || hdr_qdcount != QdCountOk) begin
                parse_verdict = StFormErr;
                phase = PhDone;
              end else begin
                phase = PhLabelLen;
              end
            end
          end
        end
        PhLabelLen: begin
          if (b > MaxLabel || p + 1 + b + QtailLen > eff_len) begin
            parse_verdict = StFormErr;
            phase = PhDone;
          end else if (b == 0) begin
            label_left = QtailLen;
            phase = PhTypeClass;
          end else begin
            label_left = b;
            phase = PhLabelBody;
          end
        end
        PhLabelBody: begin
          label_left--;
          if (label_left == 0) phase = PhLabelLen;
        end
        PhTypeClass: begin
          if (label_left == 2) begin
            qclass_seen = {w.data_byte, 8'h00};
          end else if (label_left == 1) begin
            qclass_seen[7:0] = w.data_byte;
            question_end = p + 1;
            parse_verdict = (qclass_seen != ClassIn) ? StNotImpl : StForward;
            phase = PhDone;
          end
          label_left--;
        end
        default: ;
      endcase
    end
    if (msg_pos < PosMax) msg_pos++;
    if (w.last) begin
      if (eff_len <= HdrLen) st = StDropped;
      else if (phase != PhDone) st = StFormErr;
      else st = parse_verdict;
      qlen = 0;
      if (st == StForward) begin
        qlen = (question_end >= HdrLen) ? question_end - HdrLen : 0;
        if (qlen > QlenMax) qlen = QlenMax;
      end
      v.query_id = hdr_id;
      v.status = st;
      v.question_length = 9'(qlen);
      verdict_q.push_back(v);
      clear_parse();
    end
  endtask

  task automatic send_byte(input logic [7:0] data, input logic [9:0] len, input logic is_last);
    in_word_t w;
    w.data_byte = data;
    w.msg_length = len;
    w.last = is_last;
    while ($urandom_range(0, 99) < in_idle_pct) begin
      byte_if.valid <= 1'b0;
      @(negedge clk);
    end
    byte_if.valid      <= 1'b1;
    byte_if.data_byte  <= data;
    byte_if.msg_length <= len;
    byte_if.last       <= is_last;
    @(posedge clk);
    while (!byte_if.ready) @(posedge clk);
    predict_verdict(w);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_message(input byte_q_t m, input logic [9:0] len, input int unsigned n_send);
    for (int unsigned i = 0; i < n_send; i++) send_byte(m[i], len, i == n_send - 1);
    msgs_sent++;
  endtask

  function automatic byte_q_t build_query(input int unsigned n_labels, input int unsigned lo,
                                          input int unsigned hi, input logic [15:0] qclass,
                                          input int unsigned trailing);
    byte_q_t     m;
    logic [7:0]  flags;
    int unsigned n;
    flags = 8'($urandom);
    flags[7] = 1'b0;
    flags[1] = 1'b0;
    m.push_back(8'($urandom));
    m.push_back(8'($urandom));
    m.push_back(flags);
    m.push_back(8'($urandom));
    m.push_back(8'h00);
    m.push_back(8'h01);
    repeat (6) m.push_back(8'($urandom));
    repeat (n_labels) begin
      n = $urandom_range(lo, hi);
      m.push_back(8'(n));
      repeat (n) m.push_back(8'($urandom));
    end
    m.push_back(8'h00);
    m.push_back(8'($urandom));
    m.push_back(8'($urandom));
    m.push_back(qclass[15:8]);
    m.push_back(qclass[7:0]);
    repeat (trailing) m.push_back(8'($urandom));
    return m;
  endfunction

  task automatic send_random_message();
    byte_q_t     m;
    logic [15:0] qclass;
    int unsigned kind;
    int unsigned hi;
    int unsigned len;
    int unsigned n_send;
    kind = $urandom_range(0, 99);
    hi = ($urandom_range(0, 9) == 0) ? MaxLabel : 8;
    qclass = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'(ClassIn);
    m = build_query($urandom_range(1, 3), 1, hi, qclass,
                    ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
    len = m.size();
    n_send = m.size();
    if (kind < 60) begin
      case ($urandom_range(0, 9))
        0: len = m.size() + $urandom_range(1, 20);
        1: len = $urandom_range(MaxMessage + 1, 1023);
        default: ;
      endcase
    end else if (kind < 70) begin
      case ($urandom_range(0, 2))
        0: m[2] = m[2] | 8'h80;
        1: m[2] = m[2] | 8'h02;
        default: begin
          m[4] = 8'($urandom);
          m[5] = 8'($urandom);
        end
      endcase
    end else if (kind < 78) begin
      if ($urandom_range(0, 1) == 1) m[12] = 8'($urandom_range(MaxLabel + 1, 255));
      else len = m.size() - $urandom_range(1, 4);
    end else if (kind < 86) begin
      n_send = $urandom_range(1, m.size() - 1);
    end else if (kind < 93) begin
      m.delete();
      repeat ($urandom_range(1, 14)) m.push_back(8'($urandom));
      len = $urandom_range(0, HdrLen);
      n_send = m.size();
    end else begin
      m.delete();
      repeat ($urandom_range(1, 30)) m.push_back(8'($urandom));
      len = $urandom_range(0, 1023);
      n_send = m.size();
    end
    send_message(m, 10'(len), n_send);
  endtask

  task automatic test_directed_cases();
    byte_q_t m;
    m = build_query(1, MaxLabel, MaxLabel, ClassIn, 0);
    send_message(m, 10'(m.size()), m.size());
    m = build_query(1, 1, 5, 16'h00ff, 0);
    send_message(m, 10'(m.size()), m.size());
    // header flag and count checks
    m = build_query(1, 1, 1, ClassIn, 0);
    m[2] = m[2] | 8'h80;
    send_message(m, 10'(m.size()), m.size());
    m = build_query(1, 1, 1, ClassIn, 0);
    m[2] = m[2] | 8'h02;
    send_message(m, 10'(m.size()), m.size());
    m = build_query(1, 1, 1, ClassIn, 0);
    m[5] = 8'h00;
    send_message(m, 10'(m.size()), m.size());
    // oversize label
    m = build_query(1, 1, 1, ClassIn, 0);
    m[12] = 8'(MaxLabel + 1);
    send_message(m, 10'(m.size()), m.size());
    // type and class would run past the length
    m = build_query(1, 4, 4, ClassIn, 0);
    send_message(m, 10'(m.size() - 1), m.size());
    // too short
    m = build_query(1, 1, 1, ClassIn, 0);
    send_message(m, 10'(HdrLen), HdrLen);
    send_message(m, 10'd0, 1);
    // stream ends early in header and name
    m = build_query(2, 3, 3, ClassIn, 0);
    send_message(m, 10'(m.size()), 7);
    send_message(m, 10'(m.size()), 14);
    // header bytes past a short length skipped, then a format error at offset 12
    repeat (HdrLen) send_byte(8'($urandom), 10'd5, 1'b0);
    repeat (9) send_byte(8'($urandom), 10'd40, 1'b0);
    send_byte(8'($urandom), 10'd40, 1'b1);
    // length clipped to the maximum
    m = build_query(1, 1, 3, ClassIn, 2);
    m[0] = 8'hff;
    m[1] = 8'hff;
    send_message(m, 10'h3ff, m.size());
  endtask

  task automatic test_random_queries();
    int unsigned start_bytes;
    int unsigned start_msgs;
    in_idle_pct = 18;
    out_idle_pct = 18;
    start_bytes = bytes_sent;
    start_msgs = msgs_sent;
    while (bytes_sent - start_bytes < RandomBytes || msgs_sent - start_msgs < RandomMsgs)
      send_random_message();
  endtask

  task automatic test_no_idle();
    in_idle_pct = 0;
    out_idle_pct = 0;
    repeat (3) send_random_message();
    in_idle_pct = 18;
    out_idle_pct = 18;
  endtask

  task automatic test_output_backpressure();
    byte_q_t m;
    in_idle_pct = 0;
    hold_req = 1'b1;
    repeat (4) begin
      if ($urandom_range(0, 1) == 1) begin
        m = build_query(1, 1, 3, ClassIn, 0);
        send_message(m, 10'(m.size()), m.size());
      end else begin
        m.delete();
        repeat (4) m.push_back(8'($urandom));
        send_message(m, 10'd4, 4);
      end
    end
    in_idle_pct = 18;
  endtask

  task automatic test_missing_last();
    byte_q_t m;
    m = build_query(1, 2, 6, ClassIn, 0);
    for (int unsigned i = 0; i < m.size(); i++) send_byte(m[i], 10'(m.size()), 1'b0);
    repeat (6) send_byte(8'($urandom), 10'(m.size()), 1'b0);
    send_byte(8'($urandom), 10'(m.size()), 1'b1);
    m = build_query(1, 1, 4, ClassIn, 0);
    send_message(m, 10'(m.size()), m.size());
  endtask

  // verdict sink: random ready, plus a long hold-off on request
  initial begin : verdict_sink
    int unsigned hold_left;
    hold_left = 0;
    verdict_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HoldCycles;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        verdict_if.ready <= 1'b0;
      end else begin
        verdict_if.ready <= ($urandom_range(0, 99) >= out_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    res_t exp_v;
    if (rst_n && verdict_if.valid && verdict_if.ready) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected word id=%h status=%0d qlen=%0d", $time,
                 verdict_if.query_id, verdict_if.status, verdict_if.question_length);
        errors++;
      end else begin
        exp_v = verdict_q.pop_front();
        if (verdict_if.query_id !== exp_v.query_id) begin
          $display("%0t: query_id expected %h actual %h", $time, exp_v.query_id,
                   verdict_if.query_id);
          errors++;
        end
        if (verdict_if.status !== exp_v.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_v.status,
                   verdict_if.status);
          errors++;
        end
        if (verdict_if.question_length !== exp_v.question_length) begin
          $display("%0t: question_length expected %0d actual %0d", $time,
                   exp_v.question_length, verdict_if.question_length);
          errors++;
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk);
      if (!rst_n || (byte_if.valid && byte_if.ready) || (verdict_if.valid && verdict_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    hold_req = 1'b0;
    errors = 0;
    bytes_sent = 0;
    msgs_sent = 0;
    in_idle_pct = 18;
    out_idle_pct = 18;
    byte_if.valid = 1'b0;
    byte_if.data_byte = '0;
    byte_if.msg_length = '0;
    byte_if.last = 1'b0;
    clear_parse();
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_directed_cases();
    test_random_queries();
    test_no_idle();
    test_output_backpressure();
    test_missing_last();
    byte_if.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0 && verdict_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
